>>> src/u8cc_pkg.sv
package u8cc_pkg;

   // Result count width and its saturation value.
   localparam int CountWidth = 31;
   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   // Depth of the queue between the front and back parts.
   localparam int QueueDepth = 4;
   localparam int QueueAddrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   // Byte values that bound the lead and continuation ranges.
   localparam logic [7:0] LeadMinMulti = 8'hC2;
   localparam logic [7:0] LeadMax = 8'hF4;
   localparam logic [7:0] LeadE0 = 8'hE0;
   localparam logic [7:0] LeadED = 8'hED;
   localparam logic [7:0] LeadF0 = 8'hF0;
   localparam logic [7:0] LeadF4 = 8'hF4;
   localparam logic [7:0] ContMin = 8'h80;
   localparam logic [7:0] ContMax = 8'hBF;
   localparam logic [7:0] ContMinE0 = 8'hA0;
   localparam logic [7:0] ContMaxED = 8'h9F;
   localparam logic [7:0] ContMinF0 = 8'h90;
   localparam logic [7:0] ContMaxF4 = 8'h8F;

   // Lead bytes that restrict the range of the second byte.
   typedef enum logic [2:0] {
      LEAD_PLAIN,
      LEAD_E0,
      LEAD_ED,
      LEAD_F0,
      LEAD_F4
   } lead_kind_type;

   // One classified byte as it travels from the front to the back part.
   typedef struct packed {
      logic          bad_lead;     // Illegal as a lead byte.
      logic [1:0]    cont_count;   // Continuation bytes this lead byte opens.
      lead_kind_type lead_kind;
      logic          cont_plain;   // In 80..BF.
      logic          cont_e0;      // In A0..BF.
      logic          cont_ed;      // In 80..9F.
      logic          cont_f0;      // In 90..BF.
      logic          cont_f4;      // In 80..8F.
      logic          last;
   } item_type;

   // Classify one byte as both a lead byte and a continuation byte.
   function automatic item_type classify(input logic [7:0] b, input logic last);
      item_type it;
      it.bad_lead = ((b >= ContMin) && (b < LeadMinMulti)) || (b > LeadMax);
      if (b[7] == 1'b0) begin
         it.cont_count = 2'd0;
      end else if (b[7:5] == 3'b110) begin
         it.cont_count = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         it.cont_count = 2'd2;
      end else begin
         it.cont_count = 2'd3;
      end
      case (b)
         LeadE0:  it.lead_kind = LEAD_E0;
         LeadED:  it.lead_kind = LEAD_ED;
         LeadF0:  it.lead_kind = LEAD_F0;
         LeadF4:  it.lead_kind = LEAD_F4;
         default: it.lead_kind = LEAD_PLAIN;
      endcase
      it.cont_plain = (b >= ContMin) && (b <= ContMax);
      it.cont_e0 = (b >= ContMinE0) && (b <= ContMax);
      it.cont_ed = (b >= ContMin) && (b <= ContMaxED);
      it.cont_f0 = (b >= ContMinF0) && (b <= ContMax);
      it.cont_f4 = (b >= ContMin) && (b <= ContMaxF4);
      it.last = last;
      return it;
   endfunction

endpackage

>>> src/utf8_validating_char_counter.sv
// Channel   Direction  Ports                                   Handshake
// req       in         req_data_byte[7:0], req_last_byte       req_valid / req_stall
// rsp       out        rsp_char_count[30:0], rsp_valid_res     rsp_valid / rsp_stall
//
// One byte is accepted per cycle while req_stall is low; rsp_valid rises once the final byte has passed
// through the queue into the output register, and later when earlier bytes still wait in the queue.
// The rate is set by the decoder register loop in the back part, which updates once per byte.
// Reset is synchronous and active high; it empties the queue and clears the decoder.
// A stalled result holds the back part only at the next final byte; the four-entry queue
// absorbs bytes meanwhile, and req_stall rises when it is full.
module utf8_validating_char_counter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [u8cc_pkg::CountWidth-1:0]   rsp_char_count,
   output logic                              rsp_valid_res
);

   logic               queue_full;
   logic               push;
   u8cc_pkg::item_type push_item;
   logic               pop;
   logic               head_valid;
   u8cc_pkg::item_type head_item;

   // Front part: accept and classify each byte.
   u8cc_front u_front (
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push          (push),
      .push_item     (push_item)
   );

   // Queue between the two parts.
   u8cc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (head_valid),
      .head_item (head_item)
   );

   // Back part: sequence decoding, counting and the result register.
   u8cc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_char_count (rsp_char_count),
      .rsp_valid_res  (rsp_valid_res)
   );

endmodule

>>> src/u8cc_front.sv
module u8cc_front (
   input  logic               req_valid,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   input  logic               queue_full,
   output logic               req_stall,
   output logic               push,
   output u8cc_pkg::item_type push_item
);

   // Accept while the queue has room; classify the byte on the way in.
   assign req_stall = queue_full;
   assign push = req_valid && !queue_full;
   assign push_item = u8cc_pkg::classify(req_data_byte, req_last_byte);

endmodule

>>> src/u8cc_queue.sv
module u8cc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8cc_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output u8cc_pkg::item_type head_item
);

   u8cc_pkg::item_type mem_ff [u8cc_pkg::QueueDepth];
   logic [u8cc_pkg::QueueAddrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [u8cc_pkg::QueueAddrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [u8cc_pkg::QueueCountWidth-1:0] count_ff, count_in;

   assign full = (count_ff == u8cc_pkg::QueueCountWidth'(u8cc_pkg::QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/u8cc_back.sv
module u8cc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  u8cc_pkg::item_type                head_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [u8cc_pkg::CountWidth-1:0]   rsp_char_count,
   output logic                              rsp_valid_res
);

   logic [1:0]                      remaining_ff, remaining_in;
   u8cc_pkg::lead_kind_type         lead_kind_ff, lead_kind_in;
   logic                            second_ff, second_in;
   logic [u8cc_pkg::CountWidth-1:0] count_ff, count_in;
   logic                            error_ff, error_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [u8cc_pkg::CountWidth-1:0] rsp_count_ff, rsp_count_in;
   logic                            rsp_ok_ff, rsp_ok_in;
   logic                            out_free;
   logic                            cont_ok;
   logic [1:0]                      rem_next;
   logic [u8cc_pkg::CountWidth-1:0] count_sat;
   logic                            verdict;

   // A final byte needs the output register free; other bytes go straight on.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop = head_valid && (!head_item.last || out_free);
   assign count_sat = (count_ff == u8cc_pkg::CountMax) ? count_ff : count_ff + 1'b1;

   // Continuation range, narrowed for the second byte after special leads.
   always_comb begin
      cont_ok = head_item.cont_plain;
      if (second_ff) begin
         case (lead_kind_ff)
            u8cc_pkg::LEAD_E0: cont_ok = head_item.cont_e0;
            u8cc_pkg::LEAD_ED: cont_ok = head_item.cont_ed;
            u8cc_pkg::LEAD_F0: cont_ok = head_item.cont_f0;
            u8cc_pkg::LEAD_F4: cont_ok = head_item.cont_f4;
            default:           cont_ok = head_item.cont_plain;
         endcase
      end
   end

   // Decoder state update for one byte.
   always_comb begin
      rem_next = remaining_ff - 1'b1;
      remaining_in = remaining_ff;
      lead_kind_in = lead_kind_ff;
      second_in = second_ff;
      count_in = count_ff;
      error_in = error_ff;
      if (!error_ff) begin
         if (remaining_ff == 2'd0) begin
            if (head_item.bad_lead) begin
               error_in = 1'b1;
            end else if (head_item.cont_count == 2'd0) begin
               count_in = count_sat;
            end else begin
               remaining_in = head_item.cont_count;
               lead_kind_in = head_item.lead_kind;
               second_in = 1'b1;
            end
         end else if (!cont_ok) begin
            error_in = 1'b1;
         end else begin
            second_in = 1'b0;
            remaining_in = rem_next;
            if (rem_next == 2'd0) begin
               count_in = count_sat;
            end
         end
      end
      verdict = !error_in && (remaining_in == 2'd0);
      rsp_count_in = verdict ? count_in : '0;
      rsp_ok_in = verdict;
      // The final byte closes the string and clears the decoder.
      if (head_item.last) begin
         remaining_in = 2'd0;
         lead_kind_in = u8cc_pkg::LEAD_PLAIN;
         second_in = 1'b0;
         count_in = '0;
         error_in = 1'b0;
      end
   end

   // The output register holds a result until the receiver takes it.
   always_comb begin
      if (pop && head_item.last) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 2'd0;
         lead_kind_ff <= u8cc_pkg::LEAD_PLAIN;
         second_ff <= 1'b0;
         count_ff <= '0;
         error_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            remaining_ff <= remaining_in;
            lead_kind_ff <= lead_kind_in;
            second_ff <= second_in;
            count_ff <= count_in;
            error_ff <= error_in;
         end
      end
   end

   // Result payload loads only when a final byte is taken.
   always_ff @(posedge clock) begin
      if (pop && head_item.last) begin
         rsp_count_ff <= rsp_count_in;
         rsp_ok_ff <= rsp_ok_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char_count = rsp_count_ff;
   assign rsp_valid_res = rsp_ok_ff;

endmodule

>>> verif/utf8_validating_char_counter_tb.sv
module utf8_validating_char_counter_tb;

   localparam int CycleLimit = 400000;
   localparam int ByteTarget = 1950;
   localparam int QuietFrom = 1700;
   localparam int ScriptLen = 26;

   // Verdict for one string: character count and legality flag.
   typedef struct packed {
      logic [u8cc_pkg::CountWidth-1:0] count;
      logic                            ok;
   } string_verdict_type;

   // One directed byte; the typed verdict applies only when check is set.
   typedef struct packed {
      logic [7:0]                      data;
      logic                            last;
      logic                            check;
      logic [u8cc_pkg::CountWidth-1:0] count;
      logic                            ok;
   } script_row_type;

   localparam script_row_type Script [0:ScriptLen-1] = '{
      '{8'h00, 1'b1, 1'b1, 31'd1, 1'b1},
      '{8'h7F, 1'b1, 1'b1, 31'd1, 1'b1},
      '{8'hFF, 1'b1, 1'b1, 31'd0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 31'd0, 1'b0},
      '{8'hC0, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 31'd0, 1'b0},
      '{8'hC1, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'hBF, 1'b1, 1'b1, 31'd0, 1'b0},
      '{8'hF5, 1'b1, 1'b1, 31'd0, 1'b0},
      '{8'hE0, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h9F, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h00, 1'b1, 1'b1, 31'd0, 1'b0},
      '{8'hF0, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h90, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'hBF, 1'b1, 1'b0, 31'd0, 1'b0},
      '{8'hED, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h9F, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'hBF, 1'b1, 1'b0, 31'd0, 1'b0},
      '{8'hF4, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h90, 1'b1, 1'b1, 31'd0, 1'b0},
      '{8'hE1, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 31'd0, 1'b0},
      '{8'hC2, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h41, 1'b1, 1'b0, 31'd0, 1'b0}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [7:0]                      req_data_byte = 8'h00;
   logic                            req_last_byte = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [u8cc_pkg::CountWidth-1:0] rsp_char_count;
   logic                            rsp_valid_res;

   // Typed verdict that travels alongside the byte currently offered.
   logic                            row_check = 1'b0;
   logic [u8cc_pkg::CountWidth-1:0] row_count = '0;
   logic                            row_ok = 1'b0;

   string_verdict_type verdicts[$];
   logic [7:0]         pending_bytes[$];
   int                 errors = 0;
   int                 cycles = 0;
   int                 sent = 0;
   int                 stall_left = 0;
   bit                 quiet = 1'b0;

   // Decoder state mirrored from the block.
   logic [1:0]                      conts_left;
   logic [7:0]                      lead_byte;
   logic                            second_next;
   logic [u8cc_pkg::CountWidth-1:0] chars;
   logic                            bad_seen;

   utf8_validating_char_counter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_char_count (rsp_char_count),
      .rsp_valid_res  (rsp_valid_res)
   );

   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   function automatic void clear_decoder();
      conts_left = 2'd0;
      lead_byte = 8'h00;
      second_next = 1'b0;
      chars = '0;
      bad_seen = 1'b0;
   endfunction

   function automatic void bump_chars();
      if (chars != u8cc_pkg::CountMax) begin
         chars = chars + 1'b1;
      end
   endfunction

   // Advance the decoder by one byte; a final byte yields the string's verdict.
   function automatic void validate_byte(input logic [7:0] b, input logic last,
                                         output bit emit, output string_verdict_type v);
      logic [7:0] lo;
      logic [7:0] hi;
      emit = 1'b0;
      v = '0;
      if (!bad_seen) begin
         if (conts_left == 2'd0) begin
            if ((b >= u8cc_pkg::ContMin && b < u8cc_pkg::LeadMinMulti) ||
                b > u8cc_pkg::LeadMax) begin
               bad_seen = 1'b1;
            end else if (!b[7]) begin
               bump_chars();
            end else begin
               if (b[7:5] == 3'b110) begin
                  conts_left = 2'd1;
               end else if (b[7:4] == 4'b1110) begin
                  conts_left = 2'd2;
               end else begin
                  conts_left = 2'd3;
               end
               lead_byte = b;
               second_next = 1'b1;
            end
         end else begin
            lo = u8cc_pkg::ContMin;
            hi = u8cc_pkg::ContMax;
            if (second_next) begin
               case (lead_byte)
                  u8cc_pkg::LeadE0: lo = u8cc_pkg::ContMinE0;
                  u8cc_pkg::LeadED: hi = u8cc_pkg::ContMaxED;
                  u8cc_pkg::LeadF0: lo = u8cc_pkg::ContMinF0;
                  u8cc_pkg::LeadF4: hi = u8cc_pkg::ContMaxF4;
                  default: ;
               endcase
            end
            if (b < lo || b > hi) begin
               bad_seen = 1'b1;
            end else begin
               second_next = 1'b0;
               conts_left = conts_left - 2'd1;
               if (conts_left == 2'd0) begin
                  bump_chars();
               end
            end
         end
      end
      if (last) begin
         emit = 1'b1;
         v.ok = !bad_seen && conts_left == 2'd0;
         v.count = v.ok ? chars : '0;
         clear_decoder();
      end
   endfunction

   // Every accepted byte updates the decoder; final bytes queue a verdict.
   always @(posedge clock) begin : track_requests
      bit                 emit;
      string_verdict_type v;
      if (reset) begin
         clear_decoder();
      end else if (req_valid && !req_stall) begin
         validate_byte(req_data_byte, req_last_byte, emit, v);
         if (emit) begin
            if (row_check) begin
               v.count = row_count;
               v.ok = row_ok;
            end
            verdicts.push_back(v);
         end
      end
   end

   // Each delivered transaction is compared with the oldest queued verdict.
   always @(posedge clock) begin : check_results
      string_verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts.size() == 0) begin
            $error("unexpected result: char_count %0d valid_res %0d",
                   rsp_char_count, rsp_valid_res);
            errors++;
         end else begin
            want = verdicts.pop_front();
            if (rsp_char_count !== want.count) begin
               $error("char_count: expected %0d, got %0d", want.count, rsp_char_count);
               errors++;
            end
            if (rsp_valid_res !== want.ok) begin
               $error("valid_res: expected %0d, got %0d", want.ok, rsp_valid_res);
               errors++;
            end
         end
      end
   end

   // Receiver stalls in random bursts, none once the run turns quiet.
   always @(posedge clock) begin : result_backpressure
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(15, 0) == 0) begin
         stall_left = $urandom_range(11, 0);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles > CycleLimit) begin
         $display("utf8_validating_char_counter: mismatch");
         $finish;
      end
   end

   // Offer one byte, hold it until accepted, then maybe leave a gap.
   task automatic put_byte(input logic [7:0] b, input logic last, input logic check,
                           input logic [u8cc_pkg::CountWidth-1:0] count, input logic ok);
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      row_check <= check;
      row_count <= count;
      row_ok <= ok;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sent++;
      if (!quiet && $urandom_range(15, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
   endtask

   // Stop sending until every queued verdict has been delivered.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [7:0] cont_in(input logic [7:0] lo, input logic [7:0] hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   // Append one well-formed character of random length and content.
   function automatic void add_char();
      logic [7:0] lead;
      case ($urandom_range(3, 0))
         0: pending_bytes.push_back(8'($urandom_range(8'h7F, 8'h00)));
         1: begin
            pending_bytes.push_back(8'($urandom_range(8'hDF, 8'hC2)));
            pending_bytes.push_back(cont_in(u8cc_pkg::ContMin, u8cc_pkg::ContMax));
         end
         2: begin
            case ($urandom_range(3, 0))
               0: lead = u8cc_pkg::LeadE0;
               1: lead = u8cc_pkg::LeadED;
               default: lead = 8'($urandom_range(8'hEF, 8'hE0));
            endcase
            pending_bytes.push_back(lead);
            if (lead == u8cc_pkg::LeadE0) begin
               pending_bytes.push_back(cont_in(u8cc_pkg::ContMinE0, u8cc_pkg::ContMax));
            end else if (lead == u8cc_pkg::LeadED) begin
               pending_bytes.push_back(cont_in(u8cc_pkg::ContMin, u8cc_pkg::ContMaxED));
            end else begin
               pending_bytes.push_back(cont_in(u8cc_pkg::ContMin, u8cc_pkg::ContMax));
            end
            pending_bytes.push_back(cont_in(u8cc_pkg::ContMin, u8cc_pkg::ContMax));
         end
         default: begin
            lead = 8'($urandom_range(8'hF4, 8'hF0));
            pending_bytes.push_back(lead);
            if (lead == u8cc_pkg::LeadF0) begin
               pending_bytes.push_back(cont_in(u8cc_pkg::ContMinF0, u8cc_pkg::ContMax));
            end else if (lead == u8cc_pkg::LeadF4) begin
               pending_bytes.push_back(cont_in(u8cc_pkg::ContMin, u8cc_pkg::ContMaxF4));
            end else begin
               pending_bytes.push_back(cont_in(u8cc_pkg::ContMin, u8cc_pkg::ContMax));
            end
            pending_bytes.push_back(cont_in(u8cc_pkg::ContMin, u8cc_pkg::ContMax));
            pending_bytes.push_back(cont_in(u8cc_pkg::ContMin, u8cc_pkg::ContMax));
         end
      endcase
   endfunction

   // A byte that sits on or just past one of the range boundaries, or any byte.
   function automatic logic [7:0] odd_byte();
      case ($urandom_range(11, 0))
         0: return 8'hC0;
         1: return 8'hC1;
         2: return 8'hF5;
         3: return 8'hFF;
         4: return 8'h80;
         5: return 8'hBF;
         6: return 8'h8F;
         7: return 8'h90;
         8: return 8'h9F;
         9: return 8'hA0;
         default: return 8'($urandom_range(255, 0));
      endcase
   endfunction

   // Mostly legal strings; some corrupted, some cut short, some pure noise.
   function automatic void build_string();
      int pick;
      pick = $urandom_range(99, 0);
      pending_bytes.delete();
      if (pick < 10) begin
         repeat ($urandom_range(8, 1)) pending_bytes.push_back(8'($urandom_range(255, 0)));
      end else begin
         repeat ($urandom_range(6, 1)) add_char();
         if (pick < 22) begin
            pending_bytes[$urandom_range(pending_bytes.size() - 1, 0)] = odd_byte();
         end else if (pick < 30 && pending_bytes.size() > 1) begin
            void'(pending_bytes.pop_back());
         end
      end
   endfunction

   // Stimulus: reset, directed script, random strings, then the final drain.
   initial begin : stimulus
      bit mid_drained;
      mid_drained = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < ScriptLen; i++) begin
         put_byte(Script[i].data, Script[i].last, Script[i].check, Script[i].count,
                  Script[i].ok);
      end
      drain_results();

      while (sent < ByteTarget) begin
         build_string();
         for (int i = 0; i < pending_bytes.size(); i++) begin
            put_byte(pending_bytes[i], i == pending_bytes.size() - 1, 1'b0, '0, 1'b0);
         end
         if (!mid_drained && sent >= ByteTarget / 2) begin
            drain_results();
            mid_drained = 1'b1;
         end
         quiet = sent >= QuietFrom;
      end

      drain_results();
      repeat (16) @(posedge clock);
      if (errors == 0 && verdicts.size() == 0) begin
         $display("utf8_validating_char_counter: match");
      end else begin
         $display("utf8_validating_char_counter: mismatch");
      end
      $finish;
   end

endmodule

>>> sim.f
src/u8cc_pkg.sv
src/u8cc_front.sv
src/u8cc_queue.sv
src/u8cc_back.sv
src/utf8_validating_char_counter.sv
verif/utf8_validating_char_counter_tb.sv
